@@ hdl/isod_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isod_pkg
// Shared types, constants and panel flag helpers for the orientation detector
// ----------------------------------------------------------------------------
package isod_pkg;

    // configuration port
    localparam int CFG_AW     = 5;
    localparam int CFG_DW     = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ORIENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PLANE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_THR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE      = 3'd5;

    // item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_APPLY  = 1'b1;

    // shared multiply-accumulate widths
    localparam int MAC_A_W = 33;
    localparam int MAC_B_W = 17;
    localparam int PROD_W  = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = 42;

    // flat test: 10000*az^2 > 5184*s reduces to 301*az^2 > 324*(ax^2 + ay^2)
    localparam logic signed [MAC_B_W-1:0] FLAT_K_Z  = 17'sd301;
    localparam logic signed [MAC_B_W-1:0] FLAT_K_XY = 17'sd324;
    localparam logic [32:0]               FLAT_MIN_SQ = 33'd9000000;
    localparam logic signed [15:0]        GZ_LIMIT    = 16'sd30000;

    typedef struct packed {
        logic [2:0]  base_orientation;
        logic [2:0]  axis_map;
        logic [1:0]  tilt_offset_quarters;
        logic [15:0] min_in_plane;
        logic [29:0] spin_threshold;
        logic [3:0]  stable_needed;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        base_orientation:     3'd0,
        axis_map:             3'd0,
        tilt_offset_quarters: 2'd0,
        min_in_plane:         16'd2800,
        spin_threshold:       30'd120000,
        stable_needed:        4'd3
    };

    typedef enum logic [1:0] {
        MAC_NOP,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    typedef struct packed {
        t_mac_op                     op;
        logic signed [MAC_A_W-1:0]   a;
        logic signed [MAC_B_W-1:0]   b;
    } t_mac_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_GET_SXY,
        ST_GET_SZ,
        ST_MUL_B,
        ST_WAIT_A,
        ST_EVAL,
        ST_GYRO_WAIT,
        ST_SPIN_ADD,
        ST_SPIN_CMP,
        ST_DEBOUNCE,
        ST_APPLY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [1:0] a;
        logic signed [1:0] b;
        logic signed [1:0] c;
        logic signed [1:0] d;
    } t_mat;

    function automatic t_mat flags_matrix(logic [2:0] f);
        logic signed [1:0] xx;
        logic signed [1:0] xy;
        logic signed [1:0] yx;
        logic signed [1:0] yy;
        logic signed [1:0] t;
        t_mat m;
        xx = 2'sd1;
        xy = 2'sd0;
        yx = 2'sd0;
        yy = 2'sd1;
        if (f[0]) begin
            t  = xx;
            xx = yx;
            yx = t;
            t  = xy;
            xy = yy;
            yy = t;
        end
        if (f[1]) begin
            xx = -xx;
            xy = -xy;
        end
        if (f[2]) begin
            yx = -yx;
            yy = -yy;
        end
        m.a = xx;
        m.b = yx;
        m.c = xy;
        m.d = yy;
        return m;
    endfunction

    function automatic logic [2:0] rot_flags(logic [1:0] rot);
        logic [2:0] f;
        case (rot)
            2'd0:    f = 3'd0;
            2'd1:    f = 3'd3;
            2'd2:    f = 3'd6;
            default: f = 3'd5;
        endcase
        return f;
    endfunction

    // panel flags of rotation matrix times base matrix
    function automatic logic [2:0] combined_flags(logic [1:0] rot, logic [2:0] base);
        t_mat r;
        t_mat b;
        t_mat q;
        int pa;
        int pb;
        int pc;
        int pd;
        logic [2:0] res;
        logic found;
        r = flags_matrix(rot_flags(rot));
        b = flags_matrix(base);
        pa = int'(r.a) * int'(b.a) + int'(r.b) * int'(b.c);
        pb = int'(r.a) * int'(b.b) + int'(r.b) * int'(b.d);
        pc = int'(r.c) * int'(b.a) + int'(r.d) * int'(b.c);
        pd = int'(r.c) * int'(b.b) + int'(r.d) * int'(b.d);
        res   = base;
        found = 1'b0;
        for (int f = 0; f < 8; f++) begin
            q = flags_matrix(3'(f));
            if (!found && int'(q.a) == pa && int'(q.b) == pb &&
                int'(q.c) == pc && int'(q.d) == pd) begin
                res   = 3'(f);
                found = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/isod_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isod_if
// Valid/ready channels for sensor items and orientation results
// ----------------------------------------------------------------------------
interface isod_smp_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_z;
    logic               sample_ok;
    logic [9:0]         step_ms;
    logic [1:0]         apply_rotation;

    modport source (
        output valid, cmd, accel_x, accel_y, accel_z, gyro_z, sample_ok, step_ms,
               apply_rotation,
        input  ready
    );
    modport sink (
        input  valid, cmd, accel_x, accel_y, accel_z, gyro_z, sample_ok, step_ms,
               apply_rotation,
        output ready
    );
endinterface

interface isod_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] rotation;
    logic       change_proposed;
    logic       swap_xy;
    logic       flip_x;
    logic       flip_y;

    modport source (
        output valid, rotation, change_proposed, swap_xy, flip_x, flip_y,
        input  ready
    );
    modport sink (
        input  valid, rotation, change_proposed, swap_xy, flip_x, flip_y,
        output ready
    );
endinterface

@@ hdl/isod_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isod_cfg
// APB register file holding the detector configuration
// ----------------------------------------------------------------------------
module isod_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [isod_pkg::CFG_AW-1:0] paddr,
    input  logic [isod_pkg::CFG_DW-1:0] pwdata,
    output logic [isod_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output isod_pkg::t_cfg             o_cfg
);
    import isod_pkg::*;

    t_cfg                 r_cfg;
    logic [CFG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx  = paddr[CFG_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_BASE_ORIENT: r_cfg.base_orientation     <= pwdata[2:0];
                REG_AXIS_MAP:    r_cfg.axis_map             <= pwdata[2:0];
                REG_TILT_OFFSET: r_cfg.tilt_offset_quarters <= pwdata[1:0];
                REG_MIN_PLANE:   r_cfg.min_in_plane         <= pwdata[15:0];
                REG_SPIN_THR:    r_cfg.spin_threshold       <= pwdata[29:0];
                REG_STABLE:      r_cfg.stable_needed        <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_BASE_ORIENT: prdata = {29'd0, r_cfg.base_orientation};
            REG_AXIS_MAP:    prdata = {29'd0, r_cfg.axis_map};
            REG_TILT_OFFSET: prdata = {30'd0, r_cfg.tilt_offset_quarters};
            REG_MIN_PLANE:   prdata = {16'd0, r_cfg.min_in_plane};
            REG_SPIN_THR:    prdata = {2'd0, r_cfg.spin_threshold};
            REG_STABLE:      prdata = {28'd0, r_cfg.stable_needed};
            default:         prdata = '0;
        endcase
    end

endmodule

@@ hdl/isod_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isod_mac
// Shared signed multiply-accumulate, product registered before accumulation
// ----------------------------------------------------------------------------
module isod_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  isod_pkg::t_mac_req                      i_req,
    output logic signed [isod_pkg::ACC_W-1:0]       o_acc
);
    import isod_pkg::*;

    t_mac_op                   r_op;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   w_prod;

    assign w_prod = r_prod[ACC_W-1:0];
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= MAC_NOP;
            r_acc <= '0;
        end else begin
            r_op <= i_req.op;
            case (r_op)
                MAC_LOAD: r_acc <= w_prod;
                MAC_ADD:  r_acc <= r_acc + w_prod;
                MAC_SUB:  r_acc <= r_acc - w_prod;
                default:  r_acc <= r_acc;
            endcase
        end
    end

endmodule

@@ hdl/imu_screen_orientation_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_screen_orientation_detector_core
// Screen orientation detector: flat-spin integration, tilt sectors, debounce
// ----------------------------------------------------------------------------
// The block takes one item at a time. A sensor sample passes through the
// squaring and flat-test states and then the spin states or the tilt path,
// an apply item goes through its apply state and an ignored sample goes
// straight to the done state; the result is loaded into an output register
// when the work ends and a new item may be taken while it waits, but an item
// that finishes while the previous result is still held waits in its last
// state until that result is taken. The work is done by one shared 33x17
// multiply-accumulate, product registered before accumulation, which forms
// the three squares, the two flat-test products and the gyro rate times step
// in sequence. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module imu_screen_orientation_detector_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    isod_smp_if.sink                    i_smp,
    isod_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [isod_pkg::CFG_AW-1:0] paddr,
    input  logic [isod_pkg::CFG_DW-1:0] pwdata,
    output logic [isod_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import isod_pkg::*;

    t_cfg                     w_cfg;
    t_mac_req                 w_req;
    logic signed [ACC_W-1:0]  w_acc;

    t_state r_state;
    t_state n_state;

    // item registers
    logic               r_cmd;
    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;
    logic signed [15:0] r_gz;
    logic [9:0]         r_ms;
    logic [1:0]         r_apply_rot;

    logic [31:0] r_sxy;
    logic [30:0] r_sz;

    // detector state
    logic [1:0]  r_committed;
    logic [1:0]  n_committed;
    logic [1:0]  r_cand;
    logic [1:0]  n_cand;
    logic [3:0]  r_cnt;
    logic [3:0]  n_cnt;
    logic [31:0] r_spin;
    logic [31:0] n_spin;
    logic [1:0]  r_det;
    logic [1:0]  n_det;
    logic [1:0]  r_res_rot;
    logic [1:0]  n_res_rot;
    logic        r_res_prop;
    logic        n_res_prop;

    // output register
    logic       r_out_valid;
    logic       n_out_valid;
    logic [1:0] r_out_rot;
    logic       r_out_prop;
    logic [2:0] r_out_flags;

    logic w_in_xfer;
    logic w_out_load;
    logic w_flat;
    logic w_gz_ok;
    logic w_spin_gt;
    logic w_spin_lt;
    logic [32:0] w_sum;
    logic [3:0]  w_cnt_inc;

    logic signed [17:0] w_mx;
    logic signed [17:0] w_my;
    logic signed [17:0] w_tx;
    logic signed [17:0] w_ty;
    logic [17:0]        w_abs_x;
    logic [17:0]        w_abs_y;
    logic [1:0]         w_sector;
    logic [1:0]         w_tilt_det;
    logic signed [32:0] w_spin_s;
    logic signed [32:0] w_thr;

    isod_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    isod_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_acc   (w_acc)
    );

    assign i_smp.ready = (r_state == ST_IDLE);
    assign w_in_xfer   = i_smp.valid && (r_state == ST_IDLE);
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    assign o_res.valid           = r_out_valid;
    assign o_res.rotation        = r_out_rot;
    assign o_res.change_proposed = r_out_prop;
    assign o_res.swap_xy         = r_out_flags[0];
    assign o_res.flip_x          = r_out_flags[1];
    assign o_res.flip_y          = r_out_flags[2];

    // flat test
    assign w_sum  = {1'b0, r_sxy} + {2'b0, r_sz};
    assign w_flat = (w_sum >= FLAT_MIN_SQ) && !w_acc[ACC_W-1] && (w_acc != '0);
    assign w_gz_ok = (r_gz > -GZ_LIMIT) && (r_gz < GZ_LIMIT);

    // spin threshold
    assign w_spin_s  = $signed({r_spin[31], r_spin});
    assign w_thr     = $signed({3'b000, w_cfg.spin_threshold});
    assign w_spin_gt = w_spin_s > w_thr;
    assign w_spin_lt = w_spin_s < -w_thr;

    // tilt sector after axis mapping
    always_comb begin
        w_mx = $signed({{2{r_ax[15]}}, r_ax});
        w_my = $signed({{2{r_ay[15]}}, r_ay});
        if (w_cfg.axis_map[0]) begin
            w_mx = -w_mx;
        end
        if (w_cfg.axis_map[1]) begin
            w_my = -w_my;
        end
        if (w_cfg.axis_map[2]) begin
            w_tx = w_my;
            w_ty = w_mx;
        end else begin
            w_tx = w_mx;
            w_ty = w_my;
        end
        w_abs_x = w_tx[17] ? $unsigned(-w_tx) : $unsigned(w_tx);
        w_abs_y = w_ty[17] ? $unsigned(-w_ty) : $unsigned(w_ty);

        if (w_tx == '0 && w_ty == '0) begin
            w_sector = 2'd0;
        end else if (w_ty > 0 && -w_ty <= w_tx && w_tx < w_ty) begin
            w_sector = 2'd0;
        end else if (w_tx > 0 && -w_tx < w_ty && w_ty <= w_tx) begin
            w_sector = 2'd1;
        end else if (w_tx < 0 && w_tx <= w_ty && w_ty < -w_tx) begin
            w_sector = 2'd3;
        end else begin
            w_sector = 2'd2;
        end

        if (w_abs_x < {2'b00, w_cfg.min_in_plane} &&
            w_abs_y < {2'b00, w_cfg.min_in_plane}) begin
            w_tilt_det = r_committed;
        end else begin
            w_tilt_det = w_sector + w_cfg.tilt_offset_quarters;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_smp.cmd == CMD_APPLY) begin
                        n_state = ST_APPLY;
                    end else if (i_smp.sample_ok && i_smp.step_ms != '0) begin
                        n_state = ST_SQ_X;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SQ_X:      n_state = ST_SQ_Y;
            ST_SQ_Y:      n_state = ST_SQ_Z;
            ST_SQ_Z:      n_state = ST_GET_SXY;
            ST_GET_SXY:   n_state = ST_GET_SZ;
            ST_GET_SZ:    n_state = ST_MUL_B;
            ST_MUL_B:     n_state = ST_WAIT_A;
            ST_WAIT_A:    n_state = ST_EVAL;
            ST_EVAL:      n_state = w_flat ? ST_GYRO_WAIT : ST_DEBOUNCE;
            ST_GYRO_WAIT: n_state = ST_SPIN_ADD;
            ST_SPIN_ADD:  n_state = ST_SPIN_CMP;
            ST_SPIN_CMP:  n_state = ST_DEBOUNCE;
            ST_DEBOUNCE:  n_state = ST_DONE;
            ST_APPLY:     n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // multiplier requests
    always_comb begin
        w_req.op = MAC_NOP;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state)
            ST_SQ_X: begin
                w_req.op = MAC_LOAD;
                w_req.a  = $signed({{17{r_ax[15]}}, r_ax});
                w_req.b  = $signed({r_ax[15], r_ax});
            end
            ST_SQ_Y: begin
                w_req.op = MAC_ADD;
                w_req.a  = $signed({{17{r_ay[15]}}, r_ay});
                w_req.b  = $signed({r_ay[15], r_ay});
            end
            ST_SQ_Z: begin
                w_req.op = MAC_LOAD;
                w_req.a  = $signed({{17{r_az[15]}}, r_az});
                w_req.b  = $signed({r_az[15], r_az});
            end
            ST_GET_SZ: begin
                w_req.op = MAC_LOAD;
                w_req.a  = w_acc[MAC_A_W-1:0];
                w_req.b  = FLAT_K_Z;
            end
            ST_MUL_B: begin
                w_req.op = MAC_SUB;
                w_req.a  = $signed({1'b0, r_sxy});
                w_req.b  = FLAT_K_XY;
            end
            ST_EVAL: begin
                w_req.op = MAC_LOAD;
                w_req.a  = w_gz_ok ? $signed({{17{r_gz[15]}}, r_gz}) : '0;
                w_req.b  = $signed({7'd0, r_ms});
            end
            default: ;
        endcase
    end

    // detector datapath
    assign w_cnt_inc = (r_cnt == 4'd15) ? r_cnt : r_cnt + 4'd1;

    always_comb begin
        n_committed = r_committed;
        n_cand      = r_cand;
        n_cnt       = r_cnt;
        n_spin      = r_spin;
        n_det       = r_det;
        n_res_rot   = r_res_rot;
        n_res_prop  = r_res_prop;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_res_rot  = r_committed;
                    n_res_prop = 1'b0;
                end
            end
            ST_EVAL: begin
                if (!w_flat) begin
                    n_spin = '0;
                    n_det  = w_tilt_det;
                end
            end
            ST_SPIN_ADD: begin
                n_spin = r_spin + w_acc[31:0];
            end
            ST_SPIN_CMP: begin
                if (w_spin_gt) begin
                    n_spin = '0;
                    n_det  = r_committed + 2'd1;
                end else if (w_spin_lt) begin
                    n_spin = '0;
                    n_det  = r_committed + 2'd3;
                end else begin
                    n_det  = r_committed;
                end
            end
            ST_DEBOUNCE: begin
                if (r_det == r_cand) begin
                    n_cnt = w_cnt_inc;
                end else begin
                    n_cand = r_det;
                    n_cnt  = 4'd1;
                end
                if (n_cnt >= w_cfg.stable_needed && r_det != r_committed) begin
                    n_cnt      = 4'd0;
                    n_res_rot  = r_det;
                    n_res_prop = 1'b1;
                end else begin
                    n_res_rot  = r_committed;
                    n_res_prop = 1'b0;
                end
            end
            ST_APPLY: begin
                n_res_rot  = r_apply_rot;
                n_res_prop = 1'b0;
                if (r_apply_rot != r_committed) begin
                    n_committed = r_apply_rot;
                    n_cand      = r_apply_rot;
                    n_cnt       = 4'd0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_committed <= '0;
            r_cand      <= '0;
            r_cnt       <= '0;
            r_spin      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_committed <= n_committed;
            r_cand      <= n_cand;
            r_cnt       <= n_cnt;
            r_spin      <= n_spin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_det      <= n_det;
        r_res_rot  <= n_res_rot;
        r_res_prop <= n_res_prop;
        if (w_in_xfer) begin
            r_cmd       <= i_smp.cmd;
            r_ax        <= i_smp.accel_x;
            r_ay        <= i_smp.accel_y;
            r_az        <= i_smp.accel_z;
            r_gz        <= i_smp.gyro_z;
            r_ms        <= i_smp.step_ms;
            r_apply_rot <= i_smp.apply_rotation;
        end
        if (r_state == ST_GET_SXY) begin
            r_sxy <= w_acc[31:0];
        end
        if (r_state == ST_GET_SZ) begin
            r_sz <= w_acc[30:0];
        end
        if (w_out_load) begin
            r_out_rot   <= r_res_rot;
            r_out_prop  <= r_res_prop && (r_cmd == CMD_SAMPLE);
            r_out_flags <= combined_flags(r_res_rot, w_cfg.base_orientation);
        end
    end

    // checks
    a_busy_after_xfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready
    ) else $error("input accepted while an item is in flight");

    a_tilt_clears_spin: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && !w_flat) |=> (r_spin == '0)
    ) else $error("spin accumulator kept on tilt path");

    a_eval_order: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> ($past(r_state) == ST_WAIT_A)
    ) else $error("flat test evaluated before products settled");

endmodule
